[rtl/hpc_pkg.sv]
// ----------------------------------------------------------------------------
// hpc_pkg: shared types and code tables for the HPACK Huffman codec
// Canonical code ROMs: symbol to rank, rank to symbol, first rank and first
// code of each code length, plus the code-minus-rank offset of each length.
// ----------------------------------------------------------------------------
package hpc_pkg;

	localparam int LENGTH_SLOTS = 31;
	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_LEN      = 30;
	localparam int MIN_LEN      = 5;

	typedef logic [4:0]  len_t;
	typedef logic [7:0]  byte_t;
	typedef logic [29:0] win_t;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam len_t LEN_MAX = len_t'(MAX_LEN);

	// Item moving from length search to code arithmetic
	typedef struct packed {
		logic op;
		len_t len;
		win_t operand;  // shifted window on decode, rank on encode
	} stage_t;

	localparam byte_t RANK_TO_SYM [SYMBOL_COUNT] = '{
		8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116,
		8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
		8'd56, 8'd57, 8'd61, 8'd65, 8'd95, 8'd98, 8'd100, 8'd102, 8'd103, 8'd104,
		8'd108, 8'd109, 8'd110, 8'd112, 8'd114, 8'd117, 8'd58, 8'd66, 8'd67, 8'd68,
		8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78,
		8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd89,
		8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd38, 8'd42,
		8'd44, 8'd59, 8'd88, 8'd90, 8'd33, 8'd34, 8'd40, 8'd41, 8'd63, 8'd39,
		8'd43, 8'd124, 8'd35, 8'd62, 8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126,
		8'd94, 8'd125, 8'd60, 8'd96, 8'd123, 8'd92, 8'd195, 8'd208, 8'd128, 8'd130,
		8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226, 8'd153, 8'd161, 8'd167, 8'd172,
		8'd176, 8'd177, 8'd179, 8'd209, 8'd216, 8'd217, 8'd227, 8'd229, 8'd230, 8'd129,
		8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156, 8'd160, 8'd163, 8'd164,
		8'd169, 8'd170, 8'd173, 8'd178, 8'd181, 8'd185, 8'd186, 8'd187, 8'd189, 8'd190,
		8'd196, 8'd198, 8'd228, 8'd232, 8'd233, 8'd1, 8'd135, 8'd137, 8'd138, 8'd139,
		8'd140, 8'd141, 8'd143, 8'd147, 8'd149, 8'd150, 8'd151, 8'd152, 8'd155, 8'd157,
		8'd158, 8'd165, 8'd166, 8'd168, 8'd174, 8'd175, 8'd180, 8'd182, 8'd183, 8'd188,
		8'd191, 8'd197, 8'd231, 8'd239, 8'd9, 8'd142, 8'd144, 8'd145, 8'd148, 8'd159,
		8'd171, 8'd206, 8'd215, 8'd225, 8'd236, 8'd237, 8'd199, 8'd207, 8'd234, 8'd235,
		8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213, 8'd218, 8'd219,
		8'd238, 8'd240, 8'd242, 8'd243, 8'd255, 8'd203, 8'd204, 8'd211, 8'd212, 8'd214,
		8'd221, 8'd222, 8'd223, 8'd241, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd250,
		8'd251, 8'd252, 8'd253, 8'd254, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7,
		8'd8, 8'd11, 8'd12, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20,
		8'd21, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31,
		8'd127, 8'd220, 8'd249, 8'd10, 8'd13, 8'd22
	};

	localparam byte_t SYM_TO_RANK [SYMBOL_COUNT] = '{
		8'd84, 8'd145, 8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd174,
		8'd253, 8'd231, 8'd232, 8'd254, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238,
		8'd239, 8'd240, 8'd255, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
		8'd248, 8'd249, 8'd10, 8'd74, 8'd75, 8'd82, 8'd85, 8'd11, 8'd68, 8'd79,
		8'd76, 8'd77, 8'd69, 8'd80, 8'd70, 8'd12, 8'd13, 8'd14, 8'd0, 8'd1,
		8'd2, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd36, 8'd71,
		8'd92, 8'd22, 8'd83, 8'd78, 8'd86, 8'd23, 8'd37, 8'd38, 8'd39, 8'd40,
		8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50,
		8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd72, 8'd59,
		8'd73, 8'd87, 8'd95, 8'd88, 8'd90, 8'd24, 8'd93, 8'd3, 8'd25, 8'd4,
		8'd26, 8'd5, 8'd27, 8'd28, 8'd29, 8'd6, 8'd60, 8'd61, 8'd30, 8'd31,
		8'd32, 8'd7, 8'd33, 8'd62, 8'd34, 8'd8, 8'd9, 8'd35, 8'd63, 8'd64,
		8'd65, 8'd66, 8'd67, 8'd94, 8'd81, 8'd91, 8'd89, 8'd250, 8'd98, 8'd119,
		8'd99, 8'd100, 8'd120, 8'd121, 8'd122, 8'd146, 8'd123, 8'd147, 8'd148, 8'd149,
		8'd150, 8'd151, 8'd175, 8'd152, 8'd176, 8'd177, 8'd124, 8'd153, 8'd178, 8'd154,
		8'd155, 8'd156, 8'd157, 8'd106, 8'd125, 8'd158, 8'd126, 8'd159, 8'd160, 8'd179,
		8'd127, 8'd107, 8'd101, 8'd128, 8'd129, 8'd161, 8'd162, 8'd108, 8'd163, 8'd130,
		8'd131, 8'd180, 8'd109, 8'd132, 8'd164, 8'd165, 8'd110, 8'd111, 8'd133, 8'd112,
		8'd166, 8'd134, 8'd167, 8'd168, 8'd102, 8'd135, 8'd136, 8'd137, 8'd169, 8'd138,
		8'd139, 8'd170, 8'd190, 8'd191, 8'd103, 8'd96, 8'd140, 8'd171, 8'd141, 8'd186,
		8'd192, 8'd193, 8'd194, 8'd205, 8'd206, 8'd195, 8'd181, 8'd187, 8'd97, 8'd113,
		8'd196, 8'd207, 8'd208, 8'd197, 8'd209, 8'd182, 8'd114, 8'd115, 8'd198, 8'd199,
		8'd251, 8'd210, 8'd211, 8'd212, 8'd104, 8'd183, 8'd105, 8'd116, 8'd142, 8'd117,
		8'd118, 8'd172, 8'd143, 8'd144, 8'd188, 8'd189, 8'd184, 8'd185, 8'd200, 8'd173,
		8'd201, 8'd213, 8'd202, 8'd203, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd252,
		8'd219, 8'd220, 8'd221, 8'd222, 8'd223, 8'd204
	};

	localparam byte_t FIRST_RANK [LENGTH_SLOTS] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10, 8'd36, 8'd68, 8'd74,
		8'd74, 8'd79, 8'd82, 8'd84, 8'd90, 8'd92, 8'd95, 8'd95, 8'd95, 8'd95,
		8'd98, 8'd106, 8'd119, 8'd145, 8'd174, 8'd186, 8'd190, 8'd205, 8'd224, 8'd253,
		8'd253
	};

	localparam win_t FIRST_CODE [LENGTH_SLOTS] = '{
		30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd20, 30'd92, 30'd248, 30'd508,
		30'd1016, 30'd2042, 30'd4090, 30'd8184, 30'd16380, 30'd32764, 30'd65534,
		30'd131068, 30'd262136, 30'd524272, 30'd1048550, 30'd2097116, 30'd4194258,
		30'd8388568, 30'd16777194, 30'd33554412, 30'd67108832, 30'd134217694,
		30'd268435426, 30'd536870910, 30'd1073741820
	};

	// FIRST_CODE minus FIRST_RANK per length: code = rank + offset
	localparam win_t CODE_OFFSET [LENGTH_SLOTS] = '{
		30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd10, 30'd56, 30'd180, 30'd434,
		30'd942, 30'd1963, 30'd4008, 30'd8100, 30'd16290, 30'd32672, 30'd65439,
		30'd130973, 30'd262041, 30'd524177, 30'd1048452, 30'd2097010, 30'd4194139,
		30'd8388423, 30'd16777020, 30'd33554226, 30'd67108642, 30'd134217489,
		30'd268435202, 30'd536870657, 30'd1073741567
	};

endpackage

[rtl/hpc_len_find.sv]
// ----------------------------------------------------------------------------
// hpc_len_find: code length search
// Stage 1 looks up the rank of an encode byte and compares a decode window
// against every length bound. Stage 2 picks the length and aligns the code.
// ----------------------------------------------------------------------------
module hpc_len_find (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic            opcode,
	input  hpc_pkg::byte_t  symbol_in,
	input  hpc_pkg::win_t   bit_window,
	output logic            s2_valid,
	input  logic            s2_ready,
	output hpc_pkg::stage_t s2_data
);
	import hpc_pkg::*;

	logic                       valid_s1;
	logic                       op_s1;
	byte_t                      rank_s1;
	win_t                       win_s1;
	logic [MAX_LEN-1:MIN_LEN]   below_s1;
	logic [MAX_LEN-1:MIN_LEN]   below;
	logic                       valid_s2;
	stage_t                     data_s2;
	logic                       s2_free;
	len_t                       len_enc;
	len_t                       len_dec;
	stage_t                     next_s2;

	assign s2_free   = !valid_s2 || s2_ready;
	assign req_ready = !valid_s1 || s2_free;

	// window below the first code of the next length, moved to the window top
	always_comb begin
		for (int i = MIN_LEN; i < MAX_LEN; i++) begin
			below[i] = bit_window < (FIRST_CODE[i+1] << (MAX_LEN - 1 - i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			op_s1    <= opcode;
			rank_s1  <= SYM_TO_RANK[symbol_in];
			win_s1   <= bit_window;
			below_s1 <= below;
		end
	end

	// shortest length that holds the rank or the window
	always_comb begin
		len_enc = LEN_MAX;
		for (int i = MAX_LEN - 1; i > MIN_LEN; i--) begin
			if (rank_s1 < FIRST_RANK[i]) begin
				len_enc = len_t'(i - 1);
			end
		end
		len_dec = LEN_MAX;
		for (int i = MAX_LEN - 1; i >= MIN_LEN; i--) begin
			if (below_s1[i]) begin
				len_dec = len_t'(i);
			end
		end
		next_s2.op = op_s1;
		if (op_s1 == OP_DECODE) begin
			next_s2.len     = len_dec;
			next_s2.operand = win_s1 >> (LEN_MAX - len_dec);
		end else begin
			next_s2.len     = len_enc;
			next_s2.operand = {22'd0, rank_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			data_s2 <= next_s2;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

endmodule

[rtl/hpc_code_calc.sv]
// ----------------------------------------------------------------------------
// hpc_code_calc: code and rank arithmetic, symbol lookup
// Stage 3 adds the per-length offset (encode) or takes it off (decode).
// Stage 4 maps a decoded rank to its byte and holds the result for transfer.
// ----------------------------------------------------------------------------
module hpc_code_calc (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s2_valid,
	output logic            s2_ready,
	input  hpc_pkg::stage_t s2_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output hpc_pkg::byte_t  symbol_out,
	output hpc_pkg::win_t   code_bits,
	output hpc_pkg::len_t   code_length,
	output logic            error
);
	import hpc_pkg::*;

	logic   valid_s3;
	logic   op_s3;
	len_t   len_s3;
	win_t   sum_s3;
	win_t   sum;
	logic   valid_s4;
	byte_t  sym_s4;
	win_t   code_s4;
	len_t   len_s4;
	logic   err_s4;
	logic   s4_free;
	logic   rank_ok;

	assign s4_free  = !valid_s4 || rsp_ready;
	assign s2_ready = !valid_s3 || s4_free;

	always_comb begin
		if (s2_data.op == OP_DECODE) begin
			sum = s2_data.operand - CODE_OFFSET[s2_data.len];
		end else begin
			sum = s2_data.operand + CODE_OFFSET[s2_data.len];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s2_ready) begin
			valid_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s2_valid) begin
			op_s3  <= s2_data.op;
			len_s3 <= s2_data.len;
			sum_s3 <= sum;
		end
	end

	// ranks past the symbol table (end of string) flag an error
	assign rank_ok = (sum_s3[29:8] == 22'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_free) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_free && valid_s3) begin
			len_s4 <= len_s3;
			if (op_s3 == OP_DECODE) begin
				sym_s4  <= rank_ok ? RANK_TO_SYM[sum_s3[7:0]] : 8'd0;
				err_s4  <= !rank_ok;
				code_s4 <= '0;
			end else begin
				sym_s4  <= 8'd0;
				err_s4  <= 1'b0;
				code_s4 <= sum_s3;
			end
		end
	end

	assign rsp_valid   = valid_s4;
	assign symbol_out  = sym_s4;
	assign code_bits   = code_s4;
	assign code_length = len_s4;
	assign error       = err_s4;

endmodule

[rtl/hpack_canonical_huffman_codec.sv]
// ----------------------------------------------------------------------------
// hpack_canonical_huffman_codec: single-symbol static HPACK Huffman codec
// Path: a request moves through the stage 1, 2, 3 and 4 registers in order, and
// the stage 4 register drives the response.
// Throughput: one item per cycle unless stalled; four register stages, each
// able to advance on its own, so a bubble closes up behind a stalled response.
// Reset: arst_n clears all stage valid bits; the code tables are constant.
// ----------------------------------------------------------------------------
module hpack_canonical_huffman_codec (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           opcode,
	input  hpc_pkg::byte_t symbol_in,
	input  hpc_pkg::win_t  bit_window,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output hpc_pkg::byte_t symbol_out,
	output hpc_pkg::win_t  code_bits,
	output hpc_pkg::len_t  code_length,
	output logic           error
);
	import hpc_pkg::*;

	logic   s2_valid;
	logic   s2_ready;
	stage_t s2_data;

	hpc_len_find u_len_find (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.opcode     (opcode),
		.symbol_in  (symbol_in),
		.bit_window (bit_window),
		.s2_valid   (s2_valid),
		.s2_ready   (s2_ready),
		.s2_data    (s2_data)
	);

	hpc_code_calc u_code_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.s2_valid    (s2_valid),
		.s2_ready    (s2_ready),
		.s2_data     (s2_data),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.symbol_out  (symbol_out),
		.code_bits   (code_bits),
		.code_length (code_length),
		.error       (error)
	);

	// only the longest length reaches ranks past the table
	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && error |-> code_length == LEN_MAX && symbol_out == 8'd0)
		else $error("error response with short code length or nonzero symbol");

	// an encode result never carries a symbol or an error
	a_enc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && code_bits != '0 |-> symbol_out == 8'd0 && !error)
		else $error("encode response with symbol or error set");

	// every valid result has a length of at least the shortest code
	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> code_length >= len_t'(MIN_LEN))
		else $error("response code length below minimum");

endmodule
